// File: sv/i2cms_pkg.sv
package i2cms_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  localparam logic [7:0] ST_START = 8'h08;
  localparam logic [7:0] ST_RESTART = 8'h10;
  localparam logic [7:0] ST_W_ACK = 8'h18;
  localparam logic [7:0] ST_W_NACK = 8'h20;
  localparam logic [7:0] ST_TX_ACK = 8'h28;
  localparam logic [7:0] ST_TX_NACK = 8'h30;
  localparam logic [7:0] ST_LOST = 8'h38;
  localparam logic [7:0] ST_R_ACK = 8'h40;
  localparam logic [7:0] ST_R_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK = 8'h50;
  localparam logic [7:0] ST_RX_NACK = 8'h58;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_DONE = 3'd1;
  localparam logic [2:0] EV_ADDR = 3'd2;
  localparam logic [2:0] EV_DATA = 3'd3;
  localparam logic [2:0] EV_LOST = 3'd4;

  localparam logic REG_ADDR_RETRY = 1'b0;
  localparam logic REG_DATA_RETRY = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [4:0] length;
    logic [3:0] buffer_index;
    logic [7:0] write_byte;
    logic [7:0] status_code;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic       send_start;
    logic       send_byte_valid;
    logic [7:0] send_byte;
    logic       set_ack;
    logic       clear_ack;
    logic       send_stop;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [3:0] read_index;
    logic [2:0] event_res;
    logic [4:0] transferred_count;
  } result_t;

endpackage

// File: sv/i2c_master_status_sequencer_unit.sv
// I2C master status sequencer.
// Slave side (s_axis_*): one transfer per item. tuser carries the mode (start,
// load write byte, bus status); tdata carries the remaining fields.
// Master side (m_axis_*): exactly one result transfer per input transfer,
// telling the controller what to do next (start, send byte, ack control,
// stop) plus any received byte and a done/error event.
// Config side (cfg_*): cfg_index 0 writes the address retry limit, 1 the data
// retry limit; cfg_ready is always high. Write only while the block is idle.
// The input transfer is captured in the input register, decoded, then held in
// the result register. Throughput: one item per cycle while the result is not
// stalled, set by the single decode stage between those two registers.
// Reset (rst, synchronous): counts, length, address and retry count clear,
// both retry limits return to 3; the write buffer is not cleared.
// A stalled m_axis_tready holds the result; the input register still takes
// one more item, after which s_axis_tready drops until the result moves.
module i2c_master_status_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // target_address[6:0], read_not_write[7], length[12:8], buffer_index[16:13],
  // write_byte[24:17], status_code[32:25], received_byte[40:33], zero above
  input  logic [i2cms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // send_start[0], send_byte_valid[1], send_byte[9:2], set_ack[10],
  // clear_ack[11], send_stop[12], read_valid[13], read_byte[21:14],
  // read_index[25:22], event_res[28:26], transferred_count[33:29], zero above
  output logic [i2cms_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [3:0]                        cfg_data
);

  localparam int DW = i2cms_pkg::BUFFER_DEPTH;

  logic [3:0] address_retry_limit;
  logic [3:0] data_retry_limit;
  logic [4:0] byte_count, byte_count_next;
  logic [4:0] transfer_length, transfer_length_next;
  logic [7:0] address_byte, address_byte_next;
  logic [3:0] retry_count, retry_count_next;
  logic [7:0] write_store [DW];

  i2cms_pkg::item_t   item;
  logic               item_valid;
  i2cms_pkg::result_t res, res_next;
  logic               advance;

  logic [4:0] len_in;
  logic [4:0] retry_inc;
  logic [4:0] bc_inc;
  logic [5:0] bc_inc_plus;
  logic [7:0] store_byte;
  logic       has_more;

  assign cfg_ready = 1'b1;
  assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_retry_limit <= 4'd3;
      data_retry_limit <= 4'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2cms_pkg::REG_ADDR_RETRY: address_retry_limit <= cfg_data;
        i2cms_pkg::REG_DATA_RETRY: data_retry_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.mode <= s_axis_tuser;
      item.target_address <= s_axis_tdata[6:0];
      item.read_not_write <= s_axis_tdata[7];
      item.length <= s_axis_tdata[12:8];
      item.buffer_index <= s_axis_tdata[16:13];
      item.write_byte <= s_axis_tdata[24:17];
      item.status_code <= s_axis_tdata[32:25];
      item.received_byte <= s_axis_tdata[40:33];
    end
  end

  always_comb begin
    if (item.length == 5'd0) begin
      len_in = 5'd1;
    end else if ({1'b0, item.length} > 6'(DW)) begin
      len_in = 5'(DW);
    end else begin
      len_in = item.length;
    end
  end

  assign retry_inc = {1'b0, retry_count} + 5'd1;

  always_comb begin
    logic [4:0] idx;
    idx = byte_count;
    if (item.status_code == i2cms_pkg::ST_TX_ACK && byte_count < transfer_length) begin
      idx = byte_count + 5'd1;
    end
    bc_inc = idx;
    if (idx < 5'(DW)) begin
      store_byte = write_store[idx[3:0]];
    end else begin
      store_byte = 8'd0;
    end
  end

  assign has_more = bc_inc < transfer_length;
  assign bc_inc_plus = {1'b0, byte_count} + 6'd2;

  always_comb begin
    byte_count_next = byte_count;
    transfer_length_next = transfer_length;
    address_byte_next = address_byte;
    retry_count_next = retry_count;
    res_next = '0;
    case (item.mode)
      i2cms_pkg::MODE_START: begin
        transfer_length_next = len_in;
        byte_count_next = 5'd0;
        retry_count_next = 4'd0;
        address_byte_next = {item.target_address, item.read_not_write};
        res_next.send_start = 1'b1;
      end
      i2cms_pkg::MODE_STATUS: begin
        case (item.status_code)
          i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
            res_next.send_byte_valid = 1'b1;
            res_next.send_byte = address_byte;
          end
          i2cms_pkg::ST_W_ACK, i2cms_pkg::ST_TX_ACK: begin
            retry_count_next = 4'd0;
            if (has_more) begin
              byte_count_next = bc_inc;
              res_next.send_byte_valid = 1'b1;
              res_next.send_byte = store_byte;
            end else begin
              res_next.send_stop = 1'b1;
              res_next.event_res = i2cms_pkg::EV_DONE;
              res_next.transferred_count = bc_inc;
              byte_count_next = 5'd0;
              transfer_length_next = 5'd0;
            end
          end
          i2cms_pkg::ST_W_NACK, i2cms_pkg::ST_R_NACK: begin
            if (retry_inc > {1'b0, address_retry_limit}) begin
              retry_count_next = 4'd0;
              res_next.send_stop = 1'b1;
              res_next.event_res = i2cms_pkg::EV_ADDR;
            end else begin
              retry_count_next = retry_inc[3:0];
              res_next.send_byte_valid = 1'b1;
              res_next.send_byte = address_byte;
            end
          end
          i2cms_pkg::ST_TX_NACK: begin
            if (retry_inc > {1'b0, data_retry_limit}) begin
              retry_count_next = 4'd0;
              res_next.send_stop = 1'b1;
              res_next.event_res = i2cms_pkg::EV_DATA;
            end else begin
              retry_count_next = retry_inc[3:0];
              res_next.send_byte_valid = 1'b1;
              res_next.send_byte = store_byte;
            end
          end
          i2cms_pkg::ST_LOST: begin
            res_next.event_res = i2cms_pkg::EV_LOST;
          end
          i2cms_pkg::ST_R_ACK: begin
            retry_count_next = 4'd0;
            if (transfer_length <= 5'd1) begin
              res_next.clear_ack = 1'b1;
            end else begin
              res_next.set_ack = 1'b1;
            end
          end
          i2cms_pkg::ST_RX_ACK: begin
            if (byte_count < transfer_length) begin
              res_next.read_valid = 1'b1;
              res_next.read_byte = item.received_byte;
              res_next.read_index = byte_count[3:0];
              byte_count_next = byte_count + 5'd1;
              if (bc_inc_plus >= {1'b0, transfer_length}) begin
                res_next.clear_ack = 1'b1;
              end
            end else begin
              res_next.clear_ack = 1'b1;
            end
          end
          i2cms_pkg::ST_RX_NACK: begin
            res_next.transferred_count = byte_count;
            if (byte_count < transfer_length) begin
              res_next.read_valid = 1'b1;
              res_next.read_byte = item.received_byte;
              res_next.read_index = byte_count[3:0];
              res_next.transferred_count = byte_count + 5'd1;
            end
            res_next.send_stop = 1'b1;
            res_next.event_res = i2cms_pkg::EV_DONE;
            byte_count_next = 5'd0;
            transfer_length_next = 5'd0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (res_next.event_res != i2cms_pkg::EV_DONE) begin
      res_next.transferred_count = byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 5'd0;
      transfer_length <= 5'd0;
      address_byte <= 8'd0;
      retry_count <= 4'd0;
    end else if (advance) begin
      byte_count <= byte_count_next;
      transfer_length <= transfer_length_next;
      address_byte <= address_byte_next;
      retry_count <= retry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.mode == i2cms_pkg::MODE_LOAD
        && {1'b0, item.buffer_index} < 5'(DW)) begin
      write_store[item.buffer_index] <= item.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {6'd0, res.transferred_count, res.event_res, res.read_index,
                         res.read_byte, res.read_valid, res.send_stop, res.clear_ack,
                         res.set_ack, res.send_byte, res.send_byte_valid, res.send_start};

endmodule
